// File: rtl/imu_sfp_pkg.sv
package imu_sfp_pkg;

    // Byte values on the serial line.
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] CODE_ACCEL  = 8'h51;
    localparam logic [7:0] CODE_RATE   = 8'h52;
    localparam logic [7:0] CODE_ANGLE  = 8'h53;

    // Frame geometry: 11 bytes, of which the first 10 are kept.
    localparam int unsigned FRAME_LEN  = 11;
    localparam int unsigned STORED_LEN = 10;
    localparam int unsigned OFFSET_W   = 4;
    localparam logic [OFFSET_W-1:0] LAST_OFFSET = OFFSET_W'(FRAME_LEN - 1);

    // Result kind codes.
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_start;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic signed [15:0] value_x;
        logic signed [15:0] value_y;
        logic signed [15:0] value_z;
        logic [15:0]        temperature;
    } frame_item_t;

endpackage

// File: rtl/imu_serial_frame_parser.sv
// Parser for an IMU serial stream of 11-byte frames.
//
// Input channel (byte_valid / byte_stall / byte_item): one received byte per
// request, with burst_start set on the first byte after a line idle gap.
// Inside a burst, frames start at offsets 0, 11, 22 and so on, for
// FRAMES_PER_BURST frames; later bytes of the burst are ignored.
// Output channel (frame_valid / frame_stall / frame_item): one request per
// frame whose header is 0x55 and whose type code is acceleration, angular
// rate or angle. Values are raw little-endian counts; temperature is only
// filled for acceleration frames. The checksum byte is not checked.
//
// Throughput is one byte per cycle while byte_stall is low. A frame's
// result goes to the output register, or to the one-entry skid register
// behind it if the output is held; a stalled receiver does not stop input
// until both are full; byte_stall is then raised until the skid drains.
// Reset clears the burst position (the next byte is taken as offset 0) and
// empties both output registers; stored frame bytes are not cleared.
module imu_serial_frame_parser
    import imu_sfp_pkg::*;
#(
    parameter int unsigned FRAMES_PER_BURST = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  byte_item_t  byte_item,
    output logic        frame_valid,
    input  logic        frame_stall,
    output frame_item_t frame_item
);

    localparam int unsigned FRAME_W = $clog2(FRAMES_PER_BURST + 1);
    localparam logic [FRAME_W-1:0] FRAME_END = FRAME_W'(FRAMES_PER_BURST);

    // Burst position, kept as frame number and offset within the frame.
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [7:0]          frame_bytes_reg [STORED_LEN];

    frame_item_t out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    logic                accept;
    logic [OFFSET_W-1:0] cur_offset;
    logic [FRAME_W-1:0]  cur_frame;
    logic                in_frame;
    logic                store_byte;
    logic                produce;
    frame_item_t         result;
    logic                kind_ok;
    logic                out_free;

    assign byte_stall  = skid_valid_reg;
    assign accept      = byte_valid && !skid_valid_reg;
    assign frame_valid = out_valid_reg;
    assign frame_item  = out_reg;
    assign out_free    = !out_valid_reg || !frame_stall;

    // A burst start forces this byte to offset 0 of the first frame.
    always_comb
    begin
        cur_offset = byte_item.burst_start ? '0 : offset_reg;
        cur_frame  = byte_item.burst_start ? '0 : frame_reg;
        in_frame   = cur_frame < FRAME_END;
        store_byte = in_frame && (cur_offset != LAST_OFFSET);
        offset_next = cur_offset;
        frame_next  = cur_frame;
        if (in_frame)
        begin
            if (cur_offset == LAST_OFFSET)
            begin
                offset_next = '0;
                frame_next  = cur_frame + FRAME_W'(1);
            end
            else
            begin
                offset_next = cur_offset + OFFSET_W'(1);
            end
        end
    end

    // Decode the stored frame when its checksum byte arrives.
    always_comb
    begin
        kind_ok           = 1'b1;
        result.frame_kind = KIND_ACCEL;
        case (frame_bytes_reg[1])
            CODE_ACCEL: result.frame_kind = KIND_ACCEL;
            CODE_RATE:  result.frame_kind = KIND_RATE;
            CODE_ANGLE: result.frame_kind = KIND_ANGLE;
            default:    kind_ok = 1'b0;
        endcase
        result.value_x = signed'({frame_bytes_reg[3], frame_bytes_reg[2]});
        result.value_y = signed'({frame_bytes_reg[5], frame_bytes_reg[4]});
        result.value_z = signed'({frame_bytes_reg[7], frame_bytes_reg[6]});
        result.temperature = (result.frame_kind == KIND_ACCEL)
                           ? {frame_bytes_reg[9], frame_bytes_reg[8]} : 16'd0;
        produce = accept && in_frame && (cur_offset == LAST_OFFSET)
               && (frame_bytes_reg[0] == HEADER_BYTE) && kind_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            frame_reg  <= '0;
        end
        else if (accept)
        begin
            offset_reg <= offset_next;
            frame_reg  <= frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_byte)
        begin
            frame_bytes_reg[cur_offset] <= byte_item.rx_byte;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= produce;
            end
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (produce)
            begin
                out_reg <= result;
            end
        end
        else if (produce)
        begin
            skid_reg <= result;
        end
    end

    // The skid entry is only ever filled behind a held output.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output entry");

    // A held output whose receiver stalls keeps its kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_stall) |=> (out_valid_reg && $stable(out_reg.frame_kind)))
        else $error("stalled result changed");

    // The position counters stay in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (offset_reg <= LAST_OFFSET) && (frame_reg <= FRAME_END))
        else $error("burst position out of range");

    // Past the last frame of a burst no result is made.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!byte_item.burst_start && (frame_reg == FRAME_END)) |-> !produce)
        else $error("result from a byte past the last frame");

    // Temperature is zero except in acceleration frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.frame_kind != KIND_ACCEL)) |-> (out_reg.temperature == 16'd0))
        else $error("temperature set on a non-acceleration frame");

endmodule

// File: test/imu_serial_frame_parser_tb.sv
`timescale 1ns / 1ps

// Bench for the IMU frame parser.
//
// An initial block builds byte streams: a handful of hand-made bursts first,
// then random bursts that are mostly well-formed frames with random content,
// mixed with noise, cut-off frames and long tails. The streams go into a
// queue. A clocked driver feeds them to the input channel one request at a
// time. The receiver side stalls at random, and it also holds off for one long
// stretch so that the parser fills its output registers and has to stall its
// input. Every accepted byte goes through a local copy of the parser's
// behavior. That copy pushes the frame it expects onto a queue, and the
// monitor compares each accepted output request with the head of that queue.
module imu_serial_frame_parser_tb;
    import imu_sfp_pkg::*;

    localparam int unsigned FRAMES_PER_BURST = 3;
    localparam logic [5:0]  POS_MAX          = 6'd63;
    localparam int unsigned BYTES_PER_PHASE  = 270;
    localparam int unsigned HOLD_OFF_CYCLES  = 400;
    localparam int unsigned SETTLE_CYCLES    = 20;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        byte_valid  = 1'b0;
    logic        byte_stall;
    byte_item_t  byte_item   = '0;
    logic        frame_valid;
    logic        frame_stall = 1'b0;
    frame_item_t frame_item;

    imu_serial_frame_parser #(
        .FRAMES_PER_BURST (FRAMES_PER_BURST)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_item  (frame_item)
    );

    // Bytes waiting to be offered, and frames the parser is expected to emit.
    byte_item_t  pending_bytes[$];
    frame_item_t expected_frames[$];

    // Local copy of the parser state: the offset of the next byte in its
    // burst, and the first ten bytes of the frame being received.
    logic [5:0] burst_pos = '0;
    logic [7:0] frame_buf [STORED_LEN];

    int unsigned bytes_queued     = 0;
    int unsigned bytes_taken      = 0;
    int unsigned frame_bytes_sent = 0;
    int unsigned frames_checked   = 0;
    int unsigned input_stalls     = 0;
    int unsigned mismatches       = 0;
    int unsigned tx_idle_pct      = 0;
    int unsigned rx_idle_pct      = 0;
    int unsigned hold_left        = 0;
    logic        byte_taken       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Reset is held from the start and then released on a falling edge.
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Generous upper bound on the whole run.
    initial
    begin
        #2_000_000;
        $display("imu_serial_frame_parser: mismatch");
        $finish;
    end

    // Works out what one accepted byte does to the parser. When the byte is
    // the last one of a frame inside the burst, the frame is decoded and,
    // if its header and type code are good, the expected result is queued.
    task automatic parse_byte(input byte_item_t item);
        logic [5:0]  pos;
        int unsigned slot;
        int unsigned offset;
        frame_item_t res;
        logic        good;
        pos    = item.burst_start ? 6'd0 : burst_pos;
        slot   = pos / FRAME_LEN;
        offset = pos % FRAME_LEN;
        if (slot < FRAMES_PER_BURST)
        begin
            if (offset < STORED_LEN)
            begin
                frame_buf[offset] = item.rx_byte;
            end
            else
            begin
                // The checksum byte itself is never looked at.
                good = (frame_buf[0] == HEADER_BYTE);
                case (frame_buf[1])
                    CODE_ACCEL: res.frame_kind = KIND_ACCEL;
                    CODE_RATE:  res.frame_kind = KIND_RATE;
                    CODE_ANGLE: res.frame_kind = KIND_ANGLE;
                    default:    good = 1'b0;
                endcase
                if (good)
                begin
                    res.value_x     = {frame_buf[3], frame_buf[2]};
                    res.value_y     = {frame_buf[5], frame_buf[4]};
                    res.value_z     = {frame_buf[7], frame_buf[6]};
                    res.temperature = (res.frame_kind == KIND_ACCEL) ?
                                      {frame_buf[9], frame_buf[8]} : 16'd0;
                    expected_frames.push_back(res);
                end
            end
        end
        burst_pos = (pos < POS_MAX) ? pos + 6'd1 : POS_MAX;
    endtask

    function automatic int unsigned field_differs(input string name,
                                                  input logic [15:0] want,
                                                  input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Monitor: samples both channels at the rising edge. Output requests
    // are checked before the byte of this edge is predicted; a result
    // always belongs to a byte accepted at an earlier edge.
    always @(posedge clk)
    begin
        frame_item_t want;
        if (rst_n)
        begin
            if (frame_valid && !frame_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t ns: no frame expected, got kind %0d x %h y %h z %h t %h",
                             $time, frame_item.frame_kind, frame_item.value_x,
                             frame_item.value_y, frame_item.value_z,
                             frame_item.temperature);
                    mismatches++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    mismatches += field_differs("frame_kind", 16'(want.frame_kind),
                                                16'(frame_item.frame_kind));
                    mismatches += field_differs("value_x", want.value_x,
                                                frame_item.value_x);
                    mismatches += field_differs("value_y", want.value_y,
                                                frame_item.value_y);
                    mismatches += field_differs("value_z", want.value_z,
                                                frame_item.value_z);
                    mismatches += field_differs("temperature", want.temperature,
                                                frame_item.temperature);
                    frames_checked++;
                end
            end
            byte_taken = byte_valid && !byte_stall;
            if (byte_taken)
            begin
                parse_byte(byte_item);
                bytes_taken++;
            end
            if (byte_valid && byte_stall)
            begin
                input_stalls++;
            end
        end
    end

    // Driver: a new request is put up only once the last one has been
    // accepted, so a stalled payload stays put. Whether to idle is decided
    // without looking at the stall.
    always @(negedge clk)
    begin
        if (rst_n && (!byte_valid || byte_taken))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                byte_item  <= pending_bytes.pop_front();
                byte_valid <= 1'b1;
            end
            else
            begin
                byte_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whose length is
    // counted down here.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            frame_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic first);
        byte_item_t item;
        item.rx_byte     = value;
        item.burst_start = first;
        pending_bytes.push_back(item);
        bytes_queued++;
    endtask

    // Queues the first nbytes of a frame; the checksum byte is random.
    task automatic push_frame(input logic [7:0] header, input logic [7:0] code,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic [15:0] temp,
                              input logic first, input int unsigned nbytes);
        logic [7:0] seq [FRAME_LEN];
        seq = '{header, code, x[7:0], x[15:8], y[7:0], y[15:8],
                z[7:0], z[15:8], temp[7:0], temp[15:8], 8'($urandom)};
        for (int unsigned i = 0; i < nbytes; i++)
        begin
            push_byte(seq[i], first && (i == 0));
        end
        frame_bytes_sent += nbytes;
    endtask

    // Random 16-bit value with the extremes showing up now and then.
    function automatic logic [15:0] rand_word();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One random burst. Most are well-formed runs of frames; the rest are
    // line noise, frames cut short by a new burst, or long tails that push
    // the position past the last frame and into saturation.
    task automatic add_random_burst();
        int unsigned nframes;
        int unsigned len;
        logic [7:0]  header;
        logic [7:0]  code;
        if ($urandom_range(99) < 15)
        begin
            len = $urandom_range(1, 20);
            for (int unsigned i = 0; i < len; i++)
            begin
                push_byte(8'($urandom), $urandom_range(9) == 0);
            end
        end
        else
        begin
            nframes = $urandom_range(1, FRAMES_PER_BURST);
            for (int unsigned f = 0; f < nframes; f++)
            begin
                header = ($urandom_range(9) != 0) ? HEADER_BYTE : 8'($urandom);
                case ($urandom_range(9))
                    0:       code = 8'($urandom);
                    1, 2, 3: code = CODE_ACCEL;
                    4, 5, 6: code = CODE_RATE;
                    default: code = CODE_ANGLE;
                endcase
                // Now and then the last frame is broken off early.
                len = (f == nframes - 1 && $urandom_range(9) == 0) ?
                      $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
                push_frame(header, code, rand_word(), rand_word(), rand_word(),
                           rand_word(), f == 0, len);
            end
            if ($urandom_range(99) < 20)
            begin
                len = $urandom_range(1, 45);
                for (int unsigned i = 0; i < len; i++)
                begin
                    push_byte(8'($urandom), 1'b0);
                end
            end
        end
    endtask

    // The sender pauses here until every queued byte is taken and every
    // expected frame has come out.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (bytes_taken != bytes_queued || expected_frames.size() != 0);
    endtask

    task automatic add_random_bytes(input int unsigned count);
        int unsigned stop_at;
        stop_at = frame_bytes_sent + count;
        while (frame_bytes_sent < stop_at)
        begin
            add_random_burst();
        end
    endtask

    initial
    begin
        wait (rst_n);
        @(posedge clk);
        tx_idle_pct = 24;
        rx_idle_pct = 67;

        // Right after reset, with no burst start seen: the first byte is
        // taken as offset 0. Three frames fill the burst, with the extreme
        // values and a temperature on a rate frame that must read as 0.
        push_frame(HEADER_BYTE, CODE_ACCEL, 16'h7FFF, 16'h8000, 16'hFFFF,
                   16'hFFFF, 1'b0, FRAME_LEN);
        push_frame(HEADER_BYTE, CODE_RATE, 16'h0000, 16'h0001, 16'h8000,
                   16'h1234, 1'b0, FRAME_LEN);
        push_frame(HEADER_BYTE, CODE_ANGLE, 16'h8000, 16'hFFFF, 16'h7FFF,
                   16'hFFFF, 1'b0, FRAME_LEN);
        // Bytes past the last frame are ignored, including a good-looking
        // frame, while the position runs into its ceiling.
        for (int unsigned i = 0; i < 34; i++)
        begin
            push_byte(8'($urandom), 1'b0);
        end
        push_frame(HEADER_BYTE, CODE_ACCEL, 16'h1111, 16'h2222, 16'h3333,
                   16'h4444, 1'b0, FRAME_LEN);
        // A burst start in mid-frame restarts at offset 0.
        push_frame(HEADER_BYTE, CODE_ACCEL, 16'hAAAA, 16'h5555, 16'h0F0F,
                   16'hF0F0, 1'b1, 6);
        push_frame(HEADER_BYTE, CODE_ACCEL, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000, 1'b1, FRAME_LEN);
        // A bad header byte, then type codes outside the three known kinds.
        push_frame(8'hAA, CODE_ACCEL, 16'h0102, 16'h0304, 16'h0506,
                   16'h0708, 1'b1, FRAME_LEN);
        push_frame(HEADER_BYTE, 8'h50, 16'h0102, 16'h0304, 16'h0506,
                   16'h0708, 1'b0, FRAME_LEN);
        push_frame(HEADER_BYTE, 8'h54, 16'h0102, 16'h0304, 16'h0506,
                   16'h0708, 1'b0, FRAME_LEN);
        push_frame(HEADER_BYTE, 8'h00, 16'h0102, 16'h0304, 16'h0506,
                   16'h0708, 1'b1, FRAME_LEN);

        add_random_bytes(BYTES_PER_PHASE);
        wait_drained();

        // Sender mostly idle, receiver mostly ready.
        @(posedge clk);
        tx_idle_pct = 67;
        rx_idle_pct = 24;
        add_random_bytes(BYTES_PER_PHASE);
        wait_drained();

        // Full rate on both sides, opened by a long hold-off at the
        // receiver while bytes keep coming, so the parser backs up.
        @(posedge clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_bytes(BYTES_PER_PHASE);
        hold_left = HOLD_OFF_CYCLES;
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Sent %0d bytes in bursts of frames, noise and cut-off frames;",
                 bytes_taken);
        $display("checked %0d frames, input held back on %0d cycles.",
                 frames_checked, input_stalls);
        if (mismatches == 0)
        begin
            $display("imu_serial_frame_parser: match");
        end
        else
        begin
            $display("imu_serial_frame_parser: mismatch");
        end
        $finish;
    end

endmodule
